@@ rtl/tpmg_pkg.sv @@
package tpmg_pkg;

  localparam int DATA_W    = 32;
  localparam int NUM_REGS  = 8;
  localparam int ADDR_W    = 5;
  localparam int SQ_N      = 33;                 // root bits
  localparam int R2_W      = 2 * SQ_N;           // squared distance, Q34.32
  localparam int POT_QW    = 48;                 // potential quotient bits
  localparam int ACC_QW    = 96;                 // acceleration quotient bits
  localparam int DEN_W     = 99;                 // r2 * r
  localparam int POT_DELAY = ACC_QW - POT_QW + 1;
  localparam int BODY_LAT  = 3 + SQ_N + 2 + ACC_QW;
  localparam int LAT       = BODY_LAT + 2;
  localparam int SUM_W     = ACC_QW + 2;

  typedef enum logic [2:0] {
    REG_MASS_ONE  = 3'd0,
    REG_POS_ONE_X = 3'd1,
    REG_POS_ONE_Y = 3'd2,
    REG_POS_ONE_Z = 3'd3,
    REG_MASS_TWO  = 3'd4,
    REG_POS_TWO_X = 3'd5,
    REG_POS_TWO_Y = 3'd6,
    REG_POS_TWO_Z = 3'd7
  } reg_idx_t;

  localparam logic [DATA_W-1:0] CFG_RESET [NUM_REGS] = '{
    32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h0000_199A, 32'hFFFE_8000, 32'h0000_0000, 32'h0000_0000
  };

  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

  function automatic logic [DATA_W-1:0] sat_q(input logic [SUM_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v[SUM_W-1:DATA_W-1] == '0 || v[SUM_W-1:DATA_W-1] == '1) begin
      r = v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

endpackage

@@ rtl/tpmg_if.sv @@
interface tpmg_pos_if import tpmg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] px;
  logic [DATA_W-1:0] py;
  logic [DATA_W-1:0] pz;

  modport source (output valid, output px, output py, output pz, input ready);
  modport sink   (input valid, input px, input py, input pz, output ready);
endinterface

interface tpmg_res_if import tpmg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] potential;
  logic [DATA_W-1:0] ax;
  logic [DATA_W-1:0] ay;
  logic [DATA_W-1:0] az;
  logic              singular;

  modport source (output valid, output potential, output ax, output ay, output az,
                  output singular, input ready);
  modport sink   (input valid, input potential, input ax, input ay, input az,
                  input singular, output ready);
endinterface

@@ rtl/two_point_mass_gravity.sv @@
// Potential and acceleration of a test point in the field of two fixed masses.
// pos channel: one transfer carries a test position px, py, pz (signed Q16.16).
// res channel: one transfer per position, potential, ax, ay, az (signed
// Q16.16, saturated) and singular, set when the point lies on a body, in
// which case potential is the most negative value and the acceleration zero.
// Masses and body positions sit in eight 32-bit APB registers at 4*i; write
// them only while no position is in flight.
// Throughput is one position per cycle unless res stalls; depth is set by the
// bit-serial square root (33 stages) and the 96-stage acceleration dividers.
// A stalled res channel freezes the whole pipeline; nothing is lost and
// pos.ready drops until the result at the output is taken.
// Reset clears all valid bits and loads the register defaults: mass one
// 1.0 at the origin, mass two about 0.1 at x = -1.5.
module two_point_mass_gravity import tpmg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  tpmg_pos_if.sink          pos,
  tpmg_res_if.source        res
);

  logic [DATA_W-1:0] cfg [NUM_REGS];
  reg_idx_t          widx;

  assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign prdata = cfg[widx];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      cfg[widx] <= pwdata;
    end
  end

  logic [LAT-1:0] vld;
  logic           en;

  assign en        = !vld[LAT-1] || res.ready;
  assign pos.ready = en;
  assign res.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pos.valid};
    end
  end

  logic [2:0][DATA_W-1:0] p;
  logic [POT_QW-1:0]      pot_q [2];
  logic [2:0][ACC_QW-1:0] acc_q [2];
  logic [2:0]             acc_neg [2];
  logic                   sing [2];

  assign p = {pos.pz, pos.py, pos.px};

  tpmg_body u_body_one (
    .clk     (clk),
    .en      (en),
    .mass    (cfg[REG_MASS_ONE]),
    .cen     ({cfg[REG_POS_ONE_Z], cfg[REG_POS_ONE_Y], cfg[REG_POS_ONE_X]}),
    .pos     (p),
    .pot_q   (pot_q[0]),
    .acc_q   (acc_q[0]),
    .acc_neg (acc_neg[0]),
    .sing    (sing[0])
  );

  tpmg_body u_body_two (
    .clk     (clk),
    .en      (en),
    .mass    (cfg[REG_MASS_TWO]),
    .cen     ({cfg[REG_POS_TWO_Z], cfg[REG_POS_TWO_Y], cfg[REG_POS_TWO_X]}),
    .pos     (p),
    .pot_q   (pot_q[1]),
    .acc_q   (acc_q[1]),
    .acc_neg (acc_neg[1]),
    .sing    (sing[1])
  );

  // signed sums
  logic [SUM_W-1:0]        sm_pot;
  logic [2:0][SUM_W-1:0]   sm_acc;
  logic                    sm_sing;
  logic [2:0][SUM_W-1:0]   term_a;
  logic [2:0][SUM_W-1:0]   term_b;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      term_a[k] = acc_neg[0][k] ? SUM_W'(-{2'b0, acc_q[0][k]}) : {2'b0, acc_q[0][k]};
      term_b[k] = acc_neg[1][k] ? SUM_W'(-{2'b0, acc_q[1][k]}) : {2'b0, acc_q[1][k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_pot  <= SUM_W'(0) - {{(SUM_W-POT_QW){1'b0}}, pot_q[0]}
                           - {{(SUM_W-POT_QW){1'b0}}, pot_q[1]};
      for (int k = 0; k < 3; k++) begin
        sm_acc[k] <= term_a[k] + term_b[k];
      end
      sm_sing <= sing[0] || sing[1];
    end
  end

  // output register
  logic [DATA_W-1:0] o_pot;
  logic [DATA_W-1:0] o_ax;
  logic [DATA_W-1:0] o_ay;
  logic [DATA_W-1:0] o_az;
  logic              o_sing;

  always_ff @(posedge clk) begin
    if (en) begin
      o_sing <= sm_sing;
      if (sm_sing) begin
        o_pot <= Q_MIN;
        o_ax  <= '0;
        o_ay  <= '0;
        o_az  <= '0;
      end else begin
        o_pot <= sat_q(sm_pot);
        o_ax  <= sat_q(sm_acc[0]);
        o_ay  <= sat_q(sm_acc[1]);
        o_az  <= sat_q(sm_acc[2]);
      end
    end
  end

  assign res.potential = o_pot;
  assign res.ax        = o_ax;
  assign res.ay        = o_ay;
  assign res.az        = o_az;
  assign res.singular  = o_sing;

endmodule

@@ rtl/tpmg_body.sv @@
module tpmg_body import tpmg_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic [DATA_W-1:0]         mass,
  input  logic [2:0][DATA_W-1:0]    cen,
  input  logic [2:0][DATA_W-1:0]    pos,
  output logic [POT_QW-1:0]         pot_q,
  output logic [2:0][ACC_QW-1:0]    acc_q,
  output logic [2:0]                acc_neg,
  output logic                      sing
);

  // offsets
  logic signed [DATA_W:0]    d [3];
  logic [2:0][DATA_W-1:0]    a1_mag;
  logic [2:0]                a1_neg;
  logic [DATA_W-1:0]         a1_m;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k] = $signed({pos[k][DATA_W-1], pos[k]}) - $signed({cen[k][DATA_W-1], cen[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_m <= mass;
      for (int k = 0; k < 3; k++) begin
        a1_mag[k] <= d[k][DATA_W] ? DATA_W'(-d[k]) : d[k][DATA_W-1:0];
        a1_neg[k] <= !d[k][DATA_W] && (d[k] != '0);
      end
    end
  end

  // squares and numerators
  logic [2:0][2*DATA_W-1:0] a2_sq;
  logic [2:0][2*DATA_W-1:0] a2_num;
  logic [2:0]               a2_neg;
  logic [DATA_W-1:0]        a2_m;

  always_ff @(posedge clk) begin
    if (en) begin
      a2_m   <= a1_m;
      a2_neg <= a1_neg;
      for (int k = 0; k < 3; k++) begin
        a2_sq[k]  <= a1_mag[k] * a1_mag[k];
        a2_num[k] <= a1_m * a1_mag[k];
      end
    end
  end

  // square root, one result bit a stage
  logic [R2_W-1:0]          sq_r2   [SQ_N+1];
  logic [SQ_N+1:0]          sq_rem  [SQ_N+1];
  logic [SQ_N-1:0]          sq_root [SQ_N+1];
  logic [2:0][2*DATA_W-1:0] sq_num  [SQ_N+1];
  logic [2:0]               sq_neg  [SQ_N+1];
  logic [DATA_W-1:0]        sq_m    [SQ_N+1];
  logic                     sq_sing [SQ_N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r2[0]   <= {2'b0, a2_sq[0]} + {2'b0, a2_sq[1]} + {2'b0, a2_sq[2]};
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_num[0]  <= a2_num;
      sq_neg[0]  <= a2_neg;
      sq_m[0]    <= a2_m;
      sq_sing[0] <= (a2_sq == '0);
    end
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam int I = SQ_N - 1 - j;
    logic [SQ_N+3:0] t;
    logic [SQ_N+3:0] tr;
    logic            ge;
    assign t  = {sq_rem[j], sq_r2[j][2*I+1:2*I]};
    assign tr = {2'b0, sq_root[j], 2'b01};
    assign ge = (t >= tr);
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r2[j+1]   <= sq_r2[j];
        sq_rem[j+1]  <= ge ? (SQ_N+2)'(t - tr) : t[SQ_N+1:0];
        sq_root[j+1] <= {sq_root[j][SQ_N-2:0], ge};
        sq_num[j+1]  <= sq_num[j];
        sq_neg[j+1]  <= sq_neg[j];
        sq_m[j+1]    <= sq_m[j];
        sq_sing[j+1] <= sq_sing[j];
      end
    end
  end

  // r2 * r in two partial products
  logic [DATA_W+SQ_N-1:0]        c1_plo;
  logic [R2_W-DATA_W+SQ_N-1:0]   c1_phi;
  logic [2:0][2*DATA_W-1:0]      c1_num;
  logic [2:0]                    c1_neg;
  logic                          c1_sing;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_plo  <= sq_r2[SQ_N][DATA_W-1:0] * sq_root[SQ_N];
      c1_phi  <= sq_r2[SQ_N][R2_W-1:DATA_W] * sq_root[SQ_N];
      c1_num  <= sq_num[SQ_N];
      c1_neg  <= sq_neg[SQ_N];
      c1_sing <= sq_sing[SQ_N];
    end
  end

  // potential division m * 2^16 / r
  logic [SQ_N-1:0]   pd_div [POT_QW+1];
  logic [SQ_N-1:0]   pd_rem [POT_QW+1];
  logic [POT_QW-1:0] pd_nq  [POT_QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      pd_div[0] <= sq_root[SQ_N];
      pd_rem[0] <= '0;
      pd_nq[0]  <= {sq_m[SQ_N], 16'b0};
    end
  end

  for (genvar j = 0; j < POT_QW; j++) begin : g_pdiv
    logic [SQ_N:0] t;
    logic          ge;
    assign t  = {pd_rem[j], pd_nq[j][POT_QW-1]};
    assign ge = (t >= {1'b0, pd_div[j]});
    always_ff @(posedge clk) begin
      if (en) begin
        pd_div[j+1] <= pd_div[j];
        pd_rem[j+1] <= ge ? SQ_N'(t - {1'b0, pd_div[j]}) : t[SQ_N-1:0];
        pd_nq[j+1]  <= {pd_nq[j][POT_QW-2:0], ge};
      end
    end
  end

  logic [POT_QW-1:0] pdl [POT_DELAY];

  always_ff @(posedge clk) begin
    if (en) begin
      pdl[0] <= pd_nq[POT_QW];
      for (int i = 1; i < POT_DELAY; i++) begin
        pdl[i] <= pdl[i-1];
      end
    end
  end

  // acceleration division m * D * 2^32 / (r2 * r)
  logic [DEN_W-1:0]           dv_den  [ACC_QW+1];
  logic [2:0][DEN_W-1:0]      dv_rem  [ACC_QW+1];
  logic [2:0][ACC_QW-1:0]     dv_nq   [ACC_QW+1];
  logic [2:0]                 dv_neg  [ACC_QW+1];
  logic                       dv_sing [ACC_QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_den[0]  <= {c1_phi, 32'b0} + {{(DEN_W-DATA_W-SQ_N){1'b0}}, c1_plo};
      dv_rem[0]  <= '0;
      for (int k = 0; k < 3; k++) begin
        dv_nq[0][k] <= {c1_num[k], 32'b0};
      end
      dv_neg[0]  <= c1_neg;
      dv_sing[0] <= c1_sing;
    end
  end

  for (genvar j = 0; j < ACC_QW; j++) begin : g_adiv
    logic [2:0][DEN_W:0] t;
    logic [2:0]          ge;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        t[k]  = {dv_rem[j][k], dv_nq[j][k][ACC_QW-1]};
        ge[k] = (t[k] >= {1'b0, dv_den[j]});
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_den[j+1]  <= dv_den[j];
        dv_neg[j+1]  <= dv_neg[j];
        dv_sing[j+1] <= dv_sing[j];
        for (int k = 0; k < 3; k++) begin
          dv_rem[j+1][k] <= ge[k] ? DEN_W'(t[k] - {1'b0, dv_den[j]}) : t[k][DEN_W-1:0];
          dv_nq[j+1][k]  <= {dv_nq[j][k][ACC_QW-2:0], ge[k]};
        end
      end
    end
  end

  assign pot_q   = pdl[POT_DELAY-1];
  assign acc_q   = dv_nq[ACC_QW];
  assign acc_neg = dv_neg[ACC_QW];
  assign sing    = dv_sing[ACC_QW];

endmodule

@@ tb/tpmg_checker.sv @@
`timescale 1ns / 1ps

module tpmg_checker import tpmg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  tpmg_pos_if               pos,
  tpmg_res_if               res,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic [DATA_W-1:0] potential;
    logic [DATA_W-1:0] ax;
    logic [DATA_W-1:0] ay;
    logic [DATA_W-1:0] az;
    logic              singular;
  } field_set_t;

  logic [DATA_W-1:0] body_regs [NUM_REGS];
  field_set_t        expected_fields [$];

  function automatic logic [63:0] floor_root(input logic [127:0] x);
    logic [63:0]  root;
    logic [127:0] c;
    root = '0;
    for (int b = 40; b >= 0; b--) begin
      c = root | (64'd1 << b);
      if (c * c <= x) root = c[63:0];
    end
    return root;
  endfunction

  function automatic logic [DATA_W-1:0] clamp_q(input logic signed [129:0] v);
    logic [DATA_W-1:0] r;
    if (v > 130'sd2147483647) begin
      r = Q_MAX;
    end else if (v < -130'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic field_set_t gravity_at(input logic [DATA_W-1:0] p [3]);
    field_set_t          f;
    logic signed [129:0] pot_sum;
    logic signed [129:0] acc_sum [3];
    logic signed [32:0]  d [3];
    logic [127:0]        mag [3];
    logic [127:0]        m, r2, r, den, num, q;
    logic [DATA_W-1:0]   c;
    logic                sing;
    sing = 1'b0;
    pot_sum = '0;
    for (int k = 0; k < 3; k++) acc_sum[k] = '0;
    for (int b = 0; b < 2; b++) begin
      m = b ? body_regs[REG_MASS_TWO] : body_regs[REG_MASS_ONE];
      r2 = '0;
      for (int k = 0; k < 3; k++) begin
        c = body_regs[(b ? int'(REG_POS_TWO_X) : int'(REG_POS_ONE_X)) + k];
        d[k] = $signed({p[k][31], p[k]}) - $signed({c[31], c});
        mag[k] = d[k] < 0 ? 128'(-d[k]) : 128'(d[k]);
        r2 = r2 + mag[k] * mag[k];
      end
      if (r2 == 0) begin
        sing = 1'b1;
        continue;
      end
      r = floor_root(r2);
      q = (m << 16) / r;
      pot_sum = pot_sum - $signed({2'b00, q});
      den = r2 * r;
      for (int k = 0; k < 3; k++) begin
        num = m * mag[k];
        if (num == 0) continue;
        q = (num << 32) / den;
        if (d[k] > 0) acc_sum[k] = acc_sum[k] - $signed({2'b00, q});
        else          acc_sum[k] = acc_sum[k] + $signed({2'b00, q});
      end
    end
    if (sing) begin
      f = '{potential: Q_MIN, ax: '0, ay: '0, az: '0, singular: 1'b1};
    end else begin
      f = '{potential: clamp_q(pot_sum), ax: clamp_q(acc_sum[0]),
            ay: clamp_q(acc_sum[1]), az: clamp_q(acc_sum[2]), singular: 1'b0};
    end
    return f;
  endfunction

  task automatic report(input string name, input logic [31:0] want, input logic [31:0] got);
    errors++;
    if (errors <= 10) $display("mismatch %s: expected %h, got %h at %0t", name, want, got, $time);
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    logic [DATA_W-1:0] p [3];
    field_set_t        want;
    if (rst) begin
      body_regs <= CFG_RESET;
      expected_fields.delete();
    end else begin
      if (pos.valid && pos.ready) begin
        p[0] = pos.px;
        p[1] = pos.py;
        p[2] = pos.pz;
        expected_fields.push_back(gravity_at(p));
      end
      if (res.valid && res.ready) begin
        if (expected_fields.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer at %0t", $time);
        end else begin
          want = expected_fields.pop_front();
          if (res.potential !== want.potential) report("potential", want.potential, res.potential);
          if (res.ax !== want.ax) report("ax", want.ax, res.ax);
          if (res.ay !== want.ay) report("ay", want.ay, res.ay);
          if (res.az !== want.az) report("az", want.az, res.az);
          if (res.singular !== want.singular) report("singular", want.singular, res.singular);
        end
      end
      if (psel && penable && pwrite && pready) body_regs[paddr[ADDR_W-1:2]] <= pwdata;
    end
    pending = expected_fields.size();
  end

endmodule

@@ tb/two_point_mass_gravity_tb.sv @@
`timescale 1ns / 1ps

module two_point_mass_gravity_tb import tpmg_pkg::*; ();

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                errors;
  int                pending;
  int                idle_mode = 0;
  logic [DATA_W-1:0] body_cfg [NUM_REGS];

  tpmg_pos_if pos_ch ();
  tpmg_res_if res_ch ();

  two_point_mass_gravity dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pos(pos_ch), .res(res_ch)
  );

  tpmg_checker checker_i (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .pready(pready), .pos(pos_ch), .res(res_ch),
    .errors(errors), .pending(pending)
  );

  always #4 clk = ~clk;

  initial begin
    pos_ch.valid = 1'b0;
    pos_ch.px = '0;
    pos_ch.py = '0;
    pos_ch.pz = '0;
    res_ch.ready = 1'b0;
  end

  // receiver stalls in modes 2 and 3
  always @(negedge clk) begin
    case (idle_mode)
      2: res_ch.ready <= ($urandom_range(99) >= 61);
      3: res_ch.ready <= ($urandom_range(99) >= 36);
      default: res_ch.ready <= 1'b1;
    endcase
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_position(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z);
    int idle_pct;
    idle_pct = idle_mode == 1 ? 61 : (idle_mode == 3 ? 36 : 0);
    while ($urandom_range(99) < idle_pct) begin
      pos_ch.valid = 1'b0;
      @(negedge clk);
    end
    pos_ch.valid = 1'b1;
    pos_ch.px = x;
    pos_ch.py = y;
    pos_ch.pz = z;
    @(posedge clk);
    while (!pos_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    body_cfg[idx] = value;
    @(negedge clk);
  endtask

  task automatic drain();
    pos_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  function automatic logic [31:0] random_coord(input logic [31:0] centre, input int kind);
    logic [31:0] v;
    case (kind)
      0: v = centre;
      1: v = centre + $signed($urandom_range(262143)) - 131072;
      2: v = $urandom_range(2097151) - 1048576;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_random();
    int b, kind;
    b = $urandom_range(1);
    kind = $urandom_range(99);
    kind = kind < 10 ? 0 : (kind < 50 ? 1 : (kind < 75 ? 2 : 3));
    send_position(random_coord(body_cfg[b ? REG_POS_TWO_X : REG_POS_ONE_X], kind),
                  random_coord(body_cfg[b ? REG_POS_TWO_Y : REG_POS_ONE_Y], kind),
                  random_coord(body_cfg[b ? REG_POS_TWO_Z : REG_POS_ONE_Z], kind));
  endtask

  task automatic load_bodies(input logic [31:0] m1, input logic [31:0] x1,
                             input logic [31:0] y1, input logic [31:0] z1,
                             input logic [31:0] m2, input logic [31:0] x2,
                             input logic [31:0] y2, input logic [31:0] z2);
    write_reg(REG_MASS_ONE, m1);
    write_reg(REG_POS_ONE_X, x1);
    write_reg(REG_POS_ONE_Y, y1);
    write_reg(REG_POS_ONE_Z, z1);
    write_reg(REG_MASS_TWO, m2);
    write_reg(REG_POS_TWO_X, x2);
    write_reg(REG_POS_TWO_Y, y2);
    write_reg(REG_POS_TWO_Z, z2);
  endtask

  initial begin
    body_cfg = CFG_RESET;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: coincidence with each body, extremes, tiny and unit offsets
    send_position(32'h0, 32'h0, 32'h0);
    send_position(32'hFFFE_8000, 32'h0, 32'h0);
    send_position(32'h0001_0000, 32'h0, 32'h0);
    send_position(32'hFFFF_0000, 32'h0, 32'h0);
    send_position(32'h0, 32'h0001_0000, 32'h0);
    send_position(32'h0, 32'h0, 32'hFFFF_0000);
    send_position(32'h1, 32'h0, 32'h0);
    send_position(32'h0, 32'hFFFF_FFFF, 32'h0);
    send_position(32'hFFFE_8001, 32'h0, 32'h1);
    send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_position(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_position(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_position(32'hFFFF_4000, 32'h0, 32'h0);
    send_position(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    send_position(32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0080);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      idle_mode = phase % 4;
      case (phase)
        0: ;
        1: load_bodies($urandom, $urandom_range(524287) - 262144, $urandom, $urandom,
                       $urandom, $urandom, $urandom_range(524287) - 262144, $urandom);
        2: load_bodies(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        3: load_bodies(32'h0, 32'h0001_0000, 32'h0, 32'h0,
                       32'h0, 32'hFFFF_0000, 32'h0, 32'h0);
        4: load_bodies(32'h0000_0001, 32'h0, 32'h0, 32'h0,
                       32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        5: load_bodies($urandom_range(1048575), $urandom_range(1048575), 32'h0,
                       32'hFFF0_0000, $urandom_range(1048575), 32'h0, 32'h0010_0000, 32'h0);
        6: load_bodies($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
        default: load_bodies(32'h0001_0000, 32'h0, 32'h0, 32'h0,
                             32'h0000_199A, 32'hFFFE_8000, 32'h0, 32'h0);
      endcase
      for (int i = 0; i < 117; i++) send_random();
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
